// File: sv/software_timer_table_core_defines.svh
// assertion macros for the software timer table
`ifndef SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define STT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// stt_pkg
// shared codes and types of the software timer table
// ------------------------------------------------------------------
package stt_pkg;
  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_DELETE   = 3'd1;
  localparam logic [2:0] CMD_REWIND   = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd4;

  localparam logic [2:0] K_FIRED    = 3'd0;
  localparam logic [2:0] K_CREATED  = 3'd1;
  localparam logic [2:0] K_DELETED  = 3'd2;
  localparam logic [2:0] K_REWOUND  = 3'd3;
  localparam logic [2:0] K_NOTFOUND = 3'd4;
  localparam logic [2:0] K_FULL     = 3'd5;
  localparam logic [2:0] K_CLEARED  = 3'd6;

  localparam logic CFG_MIN_PERIOD = 1'b0;
  localparam logic CFG_SCAN       = 1'b1;

  // one memory entry of a timer
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] start;
    logic        rep;
    logic        endf;
    logic [31:0] word;
  } entry_t;

  // one result transfer
  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] id;
    logic [31:0] word;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// File: sv/software_timer_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// software_timer_table_core
// table of software timers with create, delete, rewind, tick, shutdown
// ------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one command per transfer;
//   output channel (out_valid / out_stall) carries result transfers, the
//   final one of a command has last set.
//   per-slot timer data sits in a synchronous memory; valid bits
//   and generations are flip-flops, so lookups and the free-slot search are
//   combinational and the found slot is read from memory right away.
//   create, rewind, delete: the result is loaded in S_ACT after S_READ, and
//   the next input is taken once S_WAIT sees the output drain; delete with
//   fire adds S_DEL2 for its second result. tick without scan: no result.
//   tick with a scan and shutdown walk all SLOTS entries; a free slot is
//   skipped on its valid bit, a used slot is read from memory first; on a
//   scan each fire after the first waits for the one before it to leave.
//   the walk is limited by the single read port.
//   a scan fire is held back (out_valid low) until the walk shows whether
//   it is the last result of the tick.
//   one command is in flight at a time; in_stall is high while busy.
//   a stalled output holds its result and the walk waits on it.
//   reset: synchronous, clears valid bits, generations, clock and scan mark,
//   registers return to 100 ms; no clearing pass is needed.
//   configuration writes are taken at any edge with cfg_we high.
// ------------------------------------------------------------------
`include "software_timer_table_core_defines.svh"
module software_timer_table_core #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] period_ms,
  input  wire logic        auto_repeat,
  input  wire logic        fire_on_end,
  input  wire logic [31:0] user_word,
  input  wire logic [11:0] timer_id,
  input  wire logic        fire_now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [11:0]      result_id,
  output logic [31:0]      result_word,
  output logic             last
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;  // lookup, memory address issued
  localparam logic [2:0] S_ACT  = 3'd2;  // read data available
  localparam logic [2:0] S_WAIT = 3'd3;  // wait for output to drain
  localparam logic [2:0] S_SCAN = 3'd4;  // walk slots
  localparam logic [2:0] S_DEL2 = 3'd5;  // second result of delete

  logic [2:0] state;
  logic [15:0] min_period, scan_int;
  logic [SLOTS-1:0] valid;
  logic [7:0] gen [SLOTS];
  logic [31:0] now, last_scan;

  // latched command
  logic [2:0]  cmd;
  logic [31:0] c_period, c_word;
  logic        c_rep, c_endf, c_fire;
  logic [11:0] c_id;
  logic [AW-1:0] slot;
  logic [CW-1:0] walk;
  logic          hit;
  logic          fire_held;  // scan fire in res, last not yet known

  // output register
  logic out_full;
  stt_pkg::result_t res;

  // memory
  logic            m_we;
  logic [AW-1:0]   m_waddr, m_raddr;
  stt_pkg::entry_t m_wdata, m_rdata;

  stt_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  function automatic logic [11:0] sid(input logic [7:0] g, input logic [AW-1:0] s);
    logic [31:0] t;
    t = 32'(g) * 32'(SLOTS) + 32'(s);
    return t[11:0];
  endfunction

  function automatic stt_pkg::result_t mk_res(input logic [2:0] k, input logic [11:0] i,
                                              input logic [31:0] w, input logic l);
    stt_pkg::result_t r;
    r.kind = k;
    r.id = i;
    r.word = w;
    r.last = l;
    return r;
  endfunction

  // combinational lookups over flip-flop state
  logic [AW-1:0] free_s, find_s;
  logic          free_ok, find_ok;
  always_comb begin
    free_s = '0; free_ok = 1'b0; find_s = '0; find_ok = 1'b0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid[s]) begin
        free_s = AW'(s); free_ok = 1'b1;
      end
      if (valid[s] && sid(gen[s], AW'(s)) == c_id) begin
        find_s = AW'(s); find_ok = 1'b1;
      end
    end
  end

  assign in_stall = (state != S_IDLE);
  wire in_xfer = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;
  wire out_free = !out_full || out_xfer;

  assign out_valid   = out_full && !fire_held;
  assign kind        = res.kind;
  assign result_id   = res.id;
  assign result_word = res.word;
  assign last        = res.last;

  wire [AW-1:0] wslot = walk[AW-1:0];
  wire [31:0] now_inc = now + 32'd1;
  wire due = (now - m_rdata.start) >= m_rdata.period;

  // the looked-up slot is read in S_READ so its data is ready in S_ACT
  always_comb begin
    unique case (state)
      S_READ:  m_raddr = (cmd == stt_pkg::CMD_CREATE) ? free_s : find_s;
      S_SCAN:  m_raddr = wslot;
      default: m_raddr = slot;
    endcase
  end

  // result register load and memory write decided once per cycle
  logic load, wr;
  always_comb begin
    load = 1'b0;
    wr = 1'b0;
    unique case (state)
      S_ACT, S_DEL2: load = out_free;
      S_SCAN: begin
        if (!hit) load = (walk == CW'(SLOTS)) && (cmd == stt_pkg::CMD_SHUTDOWN) && out_free;
        else if (cmd == stt_pkg::CMD_SHUTDOWN) load = m_rdata.endf && out_free;
        else load = due && !out_full;
      end
      default: ;
    endcase
    if (state == S_ACT && load) begin
      if (cmd == stt_pkg::CMD_CREATE) wr = free_ok;
      else wr = (cmd == stt_pkg::CMD_REWIND) && find_ok;
    end
    if (state == S_SCAN && hit && cmd != stt_pkg::CMD_SHUTDOWN && load) wr = m_rdata.rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      min_period <= 16'd100;
      scan_int <= 16'd100;
      valid <= '0;
      for (int s = 0; s < SLOTS; s++) gen[s] <= 8'd0;
      now <= '0;
      last_scan <= '0;
      out_full <= 1'b0;
      m_we <= 1'b0;
      hit <= 1'b0;
      fire_held <= 1'b0;
    end else begin
      m_we <= wr;
      if (load) out_full <= 1'b1;
      else if (out_xfer) out_full <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          stt_pkg::CFG_MIN_PERIOD: min_period <= cfg_data;
          stt_pkg::CFG_SCAN:       scan_int <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cmd <= command; c_period <= period_ms; c_word <= user_word;
            c_rep <= auto_repeat; c_endf <= fire_on_end; c_id <= timer_id;
            c_fire <= fire_now;
            state <= S_READ;
          end
        end
        S_READ: begin
          // lookups now use latched fields
          walk <= '0;
          hit <= 1'b0;
          unique case (cmd)
            stt_pkg::CMD_CREATE, stt_pkg::CMD_DELETE, stt_pkg::CMD_REWIND: begin
              slot <= (cmd == stt_pkg::CMD_CREATE) ? free_s : find_s;
              state <= S_ACT;
            end
            stt_pkg::CMD_TICK: begin
              now <= now_inc;
              if ((now_inc - last_scan) >= {16'd0, scan_int}) begin
                last_scan <= now_inc;
                state <= S_SCAN;
              end else state <= S_IDLE;
            end
            stt_pkg::CMD_SHUTDOWN: begin
              state <= S_SCAN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_ACT: begin
          // slot was read last cycle, m_rdata valid now
          if (out_free) begin
            unique case (cmd)
              stt_pkg::CMD_CREATE: begin
                state <= S_WAIT;
                if (!free_ok) begin
                  res <= mk_res(stt_pkg::K_FULL, '0, '0, 1'b1);
                end else begin
                  res <= mk_res(stt_pkg::K_CREATED, sid(gen[slot], slot), '0, 1'b1);
                  valid[slot] <= 1'b1;
                  m_waddr <= slot;
                  m_wdata <= {((c_period < {16'd0, min_period}) ?
                               {16'd0, min_period} : c_period),
                              now, c_rep, c_endf, c_word};
                end
              end
              stt_pkg::CMD_REWIND: begin
                state <= S_WAIT;
                if (!find_ok) begin
                  res <= mk_res(stt_pkg::K_NOTFOUND, c_id, '0, 1'b1);
                end else begin
                  res <= mk_res(stt_pkg::K_REWOUND, sid(gen[slot], slot), '0, 1'b1);
                  m_waddr <= slot;
                  m_wdata <= {m_rdata.period, now, m_rdata.rep, m_rdata.endf, m_rdata.word};
                end
              end
              default: begin
                if (!find_ok) begin
                  res <= mk_res(stt_pkg::K_NOTFOUND, c_id, '0, 1'b1);
                  state <= S_WAIT;
                end else if (c_fire) begin
                  res <= mk_res(stt_pkg::K_FIRED, sid(gen[slot], slot), m_rdata.word, 1'b0);
                  state <= S_DEL2;
                end else begin
                  res <= mk_res(stt_pkg::K_DELETED, sid(gen[slot], slot), '0, 1'b1);
                  valid[slot] <= 1'b0; gen[slot] <= gen[slot] + 8'd1;
                  state <= S_WAIT;
                end
              end
            endcase
          end
        end
        S_DEL2: begin
          if (out_free) begin
            res <= mk_res(stt_pkg::K_DELETED, sid(gen[slot], slot), '0, 1'b1);
            valid[slot] <= 1'b0; gen[slot] <= gen[slot] + 8'd1;
            state <= S_WAIT;
          end
        end
        S_SCAN: begin
          // hit=0: address wslot issued this cycle; hit=1: data ready
          if (!hit) begin
            if (walk == CW'(SLOTS)) begin
              if (cmd == stt_pkg::CMD_SHUTDOWN) begin
                if (out_free) begin
                  res <= mk_res(stt_pkg::K_CLEARED, '0, '0, 1'b1);
                  state <= S_WAIT;
                end
              end else begin
                // the held fire is the final one of this tick
                if (fire_held) begin
                  res.last <= 1'b1;
                  fire_held <= 1'b0;
                end
                state <= S_WAIT;
              end
            end else if (!valid[wslot]) walk <= walk + CW'(1);
            else hit <= 1'b1;
          end else if (cmd == stt_pkg::CMD_SHUTDOWN) begin
            if (!m_rdata.endf) begin
              valid[wslot] <= 1'b0; gen[wslot] <= gen[wslot] + 8'd1;
              hit <= 1'b0; walk <= walk + CW'(1);
            end else if (out_free) begin
              res <= mk_res(stt_pkg::K_FIRED, sid(gen[wslot], wslot), m_rdata.word, 1'b0);
              valid[wslot] <= 1'b0; gen[wslot] <= gen[wslot] + 8'd1;
              hit <= 1'b0; walk <= walk + CW'(1);
            end
          end else begin
            // scan: a fire is held until the walk finds another one or ends
            if (!due) begin
              hit <= 1'b0; walk <= walk + CW'(1);
            end else if (!out_full) begin
              res <= mk_res(stt_pkg::K_FIRED, sid(gen[wslot], wslot), m_rdata.word, 1'b0);
              fire_held <= 1'b1;
              if (m_rdata.rep) begin
                m_waddr <= wslot;
                m_wdata <= {m_rdata.period, now, m_rdata.rep, m_rdata.endf, m_rdata.word};
              end else begin
                valid[wslot] <= 1'b0; gen[wslot] <= gen[wslot] + 8'd1;
              end
              hit <= 1'b0; walk <= walk + CW'(1);
            end else if (fire_held) begin
              // another fire follows, so the held one goes out without last
              fire_held <= 1'b0;
            end
          end
        end
        S_WAIT: begin
          // drain the output before the next command
          if (!out_full || out_xfer) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STT_ASSERT_IMP(a_busy_stall, state != S_IDLE, in_stall, "accepted while busy")
  `STT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind), "held")
  `STT_ASSERT_IMP(a_full_zero, out_valid && kind == stt_pkg::K_FULL, result_id == 12'd0, "id")
endmodule
`default_nettype wire

// File: sv/stt_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------
// stt_mem
// timer entry memory, one write port, one registered read port
// ------------------------------------------------------------------
module stt_mem #(
  parameter int SLOTS = 16,
  parameter int AW = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire stt_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output stt_pkg::entry_t      rdata
);
  stt_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
